@@ design/qncull_pkg.sv @@
`default_nettype none

package qncull_pkg;

  localparam int unsigned MAX_DEPTH_DEF  = 16;
  localparam int unsigned NUM_PLANES_DEF = 6;

  localparam int unsigned POS_W    = 16;
  localparam int unsigned DEPTH_W  = 5;
  localparam int unsigned ELEV_W   = 16;
  localparam int unsigned VIS_W    = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;

  localparam int unsigned FRAC_BITS = 12;
  localparam int unsigned NORM_FRAC = 14;
  localparam int unsigned COMP_W    = 16;
  localparam int unsigned SIZE_W    = 16;
  localparam int unsigned HSCALE_W  = 16;
  localparam int unsigned ELEV_PROD_W = ELEV_W + HSCALE_W;
  localparam int unsigned ELEV_DROP   = 24 - FRAC_BITS;
  localparam int unsigned ELEV_Q_W    = ELEV_PROD_W - ELEV_DROP;

  localparam logic [CFG_IDX_W-1:0] CFG_TERRAIN = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_HSCALE  = 3'd7;

  localparam logic [HSCALE_W-1:0] HSCALE_RST = 16'd256;

  typedef enum logic [VIS_W-1:0] {
    VIS_NONE    = 2'd0,
    VIS_PARTIAL = 2'd1,
    VIS_FULL    = 2'd2
  } vis_e;

endpackage

`default_nettype wire

@@ design/quadtree_node_frustum_cull_top.sv @@
`default_nettype none

// Terrain quadtree node frustum cull.
// Request channel: start/busy plus node fields. A request is taken at every
// clock edge with start high and busy low; busy is never raised, so one node
// can enter every cycle.
// Result channel: valid_o strobes for one cycle with visibility_o
// (0 culled, 1 straddling a plane, 2 inside). The receiver cannot stall and
// none is needed: the pipe has no back-pressure.
// Throughput one per cycle; each result passes through the registered stages below.
// Stages: edge offsets and elevation product, size multiply, depth shift,
// plane-normal multiplies, plane sums, first-failing-plane select.
// Config channel: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i;
// ready is always high. Write only with the pipe empty.
// Reset: pipe valids cleared, planes and terrain size zero, height scale 1.0.
module quadtree_node_frustum_cull_top #(
  parameter int unsigned MAX_DEPTH  = qncull_pkg::MAX_DEPTH_DEF,
  parameter int unsigned NUM_PLANES = qncull_pkg::NUM_PLANES_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start,
  output      logic                                busy,
  input  wire logic [qncull_pkg::POS_W-1:0]        pos_x_i,
  input  wire logic [qncull_pkg::POS_W-1:0]        pos_y_i,
  input  wire logic [qncull_pkg::DEPTH_W-1:0]      depth_i,
  input  wire logic [qncull_pkg::ELEV_W-1:0]       min_elevation_i,
  input  wire logic [qncull_pkg::ELEV_W-1:0]       max_elevation_i,
  output      logic                                valid_o,
  output      logic [qncull_pkg::VIS_W-1:0]        visibility_o,
  input  wire logic                                cfg_valid_i,
  output      logic                                cfg_ready_o,
  input  wire logic [qncull_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [qncull_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int unsigned D_W  = $clog2(MAX_DEPTH + 1);
  localparam int unsigned A_W  = (MAX_DEPTH + 1 > 19) ? MAX_DEPTH + 1 : 19;
  localparam int unsigned P_W  = A_W + qncull_pkg::SIZE_W + 1;
  localparam int unsigned SH_W = P_W + qncull_pkg::FRAC_BITS;
  localparam int unsigned B_W  = SH_W - 1;
  localparam int unsigned M_W  = B_W + qncull_pkg::COMP_W;
  localparam int unsigned S_W  = B_W + qncull_pkg::COMP_W + 2;
  localparam int unsigned DIST_SH = qncull_pkg::FRAC_BITS + qncull_pkg::NORM_FRAC;
  localparam int unsigned LAT  = 6;

  // config registers
  logic [qncull_pkg::CFG_DATA_W-1:0] plane_q [NUM_PLANES];
  logic [31:0]                       terrain_q;
  logic [qncull_pkg::HSCALE_W-1:0]   hscale_q;

  // pipe valids
  logic s1_valid_q, s2_valid_q, s3_valid_q, s4_valid_q, s5_valid_q;

  // stage 1: edge offsets (x lo, x hi, z lo, z hi), elevation products
  logic signed [A_W-1:0]                  a_d [4];
  logic signed [A_W-1:0]                  a_q [4];
  logic [qncull_pkg::ELEV_PROD_W-1:0]     ep_q [2];
  logic [D_W-1:0]                         d_sat;
  logic [D_W-1:0]                         d1_q;
  logic [A_W-1:0]                         pw;

  // stage 2: offset times size, elevation in Q.12
  logic signed [P_W-1:0]                  prod_d [4];
  logic signed [P_W-1:0]                  prod_q [4];
  logic [qncull_pkg::ELEV_Q_W-1:0]        ey_q [2];
  logic [D_W-1:0]                         d2_q;

  // stage 3: box bounds [axis][lo/hi]
  logic signed [B_W-1:0]                  bnd_d [3][2];
  logic signed [B_W-1:0]                  bnd_q [3][2];

  // stage 4: normal times selected corner
  logic signed [M_W-1:0]                  pf_d [NUM_PLANES][3];
  logic signed [M_W-1:0]                  pn_d [NUM_PLANES][3];
  logic signed [M_W-1:0]                  pf_q [NUM_PLANES][3];
  logic signed [M_W-1:0]                  pn_q [NUM_PLANES][3];

  // stage 5: sign of plane distances
  logic [NUM_PLANES-1:0]                  far_neg_d, near_neg_d;
  logic [NUM_PLANES-1:0]                  far_neg_q, near_neg_q;

  qncull_pkg::vis_e                       vis_d;
  qncull_pkg::vis_e                       vis_q;

  logic req_acc;
  logic cfg_wr;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign req_acc     = start && !busy;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < NUM_PLANES; p++) begin
        plane_q[p] <= '0;
      end
      terrain_q <= '0;
      hscale_q  <= qncull_pkg::HSCALE_RST;
    end else if (cfg_wr) begin
      if (cfg_index_i == qncull_pkg::CFG_TERRAIN) begin
        terrain_q <= cfg_data_i[31:0];
      end else if (cfg_index_i == qncull_pkg::CFG_HSCALE) begin
        hscale_q <= cfg_data_i[qncull_pkg::HSCALE_W-1:0];
      end else begin
        for (int p = 0; p < NUM_PLANES; p++) begin
          if (cfg_index_i == qncull_pkg::CFG_IDX_W'(p)) begin
            plane_q[p] <= cfg_data_i;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
      s5_valid_q <= 1'b0;
      valid_o    <= 1'b0;
    end else begin
      s1_valid_q <= req_acc;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      s4_valid_q <= s3_valid_q;
      s5_valid_q <= s4_valid_q;
      valid_o    <= s5_valid_q;
    end
  end

  // stage 1
  always_comb begin
    if (depth_i > qncull_pkg::DEPTH_W'(MAX_DEPTH)) begin
      d_sat = D_W'(MAX_DEPTH);
    end else begin
      d_sat = D_W'(depth_i);
    end
    pw = A_W'(1) << d_sat;
    a_d[0] = A_W'({pos_x_i, 1'b0}) - pw;
    a_d[1] = A_W'({pos_x_i, 1'b0}) + A_W'(2) - pw;
    a_d[2] = A_W'({pos_y_i, 1'b0}) - pw;
    a_d[3] = A_W'({pos_y_i, 1'b0}) + A_W'(2) - pw;
  end

  // stage 2
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (i < 2) begin
        prod_d[i] = a_q[i] * $signed({1'b0, terrain_q[31:16]});
      end else begin
        prod_d[i] = a_q[i] * $signed({1'b0, terrain_q[15:0]});
      end
    end
  end

  // stage 3: scale to Q.12 and divide by 2^(d+1), rounding down
  always_comb begin
    logic signed [SH_W-1:0] ext;
    logic signed [SH_W-1:0] shd;
    logic [D_W:0]           sh;
    sh = {1'b0, d2_q} + 1'b1;
    for (int i = 0; i < 4; i++) begin
      ext = {prod_q[i], {qncull_pkg::FRAC_BITS{1'b0}}};
      shd = ext >>> sh;
      bnd_d[(i / 2) * 2][i % 2] = shd[B_W-1:0];
    end
    for (int j = 0; j < 2; j++) begin
      bnd_d[1][j] = $signed({{(B_W - qncull_pkg::ELEV_Q_W){1'b0}}, ey_q[j]});
    end
  end

  // stage 4: pick far/near corner per axis from the normal sign
  always_comb begin
    logic signed [qncull_pkg::COMP_W-1:0] n;
    for (int p = 0; p < NUM_PLANES; p++) begin
      for (int a = 0; a < 3; a++) begin
        n = $signed(plane_q[p][a*qncull_pkg::COMP_W +: qncull_pkg::COMP_W]);
        if (n > 0) begin
          pf_d[p][a] = n * bnd_q[a][1];
          pn_d[p][a] = n * bnd_q[a][0];
        end else begin
          pf_d[p][a] = n * bnd_q[a][0];
          pn_d[p][a] = n * bnd_q[a][1];
        end
      end
    end
  end

  // stage 5
  always_comb begin
    logic signed [S_W-1:0] base_s;
    logic signed [S_W-1:0] far_s;
    logic signed [S_W-1:0] near_s;
    for (int p = 0; p < NUM_PLANES; p++) begin
      base_s = S_W'($signed(plane_q[p][63:48])) <<< DIST_SH;
      far_s  = base_s + S_W'(pf_q[p][0]) + S_W'(pf_q[p][1]) + S_W'(pf_q[p][2]);
      near_s = base_s + S_W'(pn_q[p][0]) + S_W'(pn_q[p][1]) + S_W'(pn_q[p][2]);
      far_neg_d[p]  = far_s[S_W-1];
      near_neg_d[p] = near_s[S_W-1];
    end
  end

  // first failing plane decides
  always_comb begin
    vis_d = qncull_pkg::VIS_FULL;
    for (int p = NUM_PLANES - 1; p >= 0; p--) begin
      if (far_neg_q[p]) begin
        vis_d = qncull_pkg::VIS_NONE;
      end else if (near_neg_q[p]) begin
        vis_d = qncull_pkg::VIS_PARTIAL;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    d1_q  <= d_sat;
    ep_q[0] <= min_elevation_i * hscale_q;
    ep_q[1] <= max_elevation_i * hscale_q;

    prod_q <= prod_d;
    d2_q   <= d1_q;
    for (int j = 0; j < 2; j++) begin
      ey_q[j] <= ep_q[j][qncull_pkg::ELEV_PROD_W-1:qncull_pkg::ELEV_DROP];
    end

    bnd_q <= bnd_d;

    pf_q <= pf_d;
    pn_q <= pn_d;

    far_neg_q  <= far_neg_d;
    near_neg_q <= near_neg_d;

    vis_q <= vis_d;
  end

  assign visibility_o = vis_q;

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_acc |-> ##LAT valid_o)
    else $error("request did not produce a result after pipe latency");

  a_vis_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (visibility_o == qncull_pkg::VIS_NONE ||
                 visibility_o == qncull_pkg::VIS_PARTIAL ||
                 visibility_o == qncull_pkg::VIS_FULL))
    else $error("visibility code out of range");

  a_hscale_wr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_wr && cfg_index_i == qncull_pkg::CFG_HSCALE) |=>
      hscale_q == $past(cfg_data_i[qncull_pkg::HSCALE_W-1:0]))
    else $error("height scale write lost");

endmodule

`default_nettype wire
